// File: src/smru_pkg.sv
// Types and constants for the session identifier MRU list.
`timescale 1ns / 1ps
`default_nettype none

package smru_pkg;

  localparam int unsigned FIELD_W  = 64;  // identifier port width
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 4;   // reported list count width

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_COLLIDE   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic {
    KIND_INSERT   = 1'b0,
    KIND_ACTIVATE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE
  } state_e;

endpackage

`default_nettype wire

// File: src/session_id_mru_list.sv
// Session identifier MRU list: one active identifier plus a bounded inactive list.
//
// Holds one active session identifier and up to INACTIVE_DEPTH inactive ones, newest
// first. A request is either an insert (rejected if the identifier is already held
// anywhere; otherwise the old active id is pushed to the list head, evicting the tail
// when the list is full) or an activate (the id must sit in the inactive list; it is
// removed, the gap closes, the old active id goes to the head and the found id becomes
// active). Every request yields exactly one response carrying status, eviction info,
// the active identifier and the list count. Only the low ID_BITS bits of session_id_i
// are used. From acceptance until the response is valid, a request goes through S_SEARCH
// and S_UPDATE: the list sits in a ring of registers that rotates once past a single
// shared comparator in S_SEARCH, then S_UPDATE applies the update. The input is ready
// again the cycle after the update, so a new request is taken only once the previous one
// has been applied in S_UPDATE. The input stalls while a request is in progress; the
// response sits in an output register, so the next request may be accepted while the
// previous response is still stalled, and its update waits until that response leaves.
// inactive_count_o carries the low 4 bits of the count. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module session_id_mru_list #(
  parameter int unsigned ID_BITS        = 64,
  parameter int unsigned INACTIVE_DEPTH = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           kind_i,
  input  wire logic [smru_pkg::FIELD_W-1:0]   session_id_i,

  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [smru_pkg::STATUS_W-1:0]       status_o,
  output logic                                evicted_flag_o,
  output logic [smru_pkg::FIELD_W-1:0]        evicted_id_o,
  output logic                                active_valid_o,
  output logic [smru_pkg::FIELD_W-1:0]        active_id_o,
  output logic [smru_pkg::COUNT_W-1:0]        inactive_count_o
);

  import smru_pkg::*;

  localparam int unsigned IDX_W = (INACTIVE_DEPTH > 1) ? $clog2(INACTIVE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(INACTIVE_DEPTH + 1);

  // FSM
  state_e state_q, state_d;

  // request being worked on
  kind_e              kind_q, kind_d;
  logic [ID_BITS-1:0] id_q, id_d;

  // search sequencer
  logic [IDX_W-1:0]   step_q, step_d;
  logic               hit_q, hit_d;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d;

  // list state
  logic [ID_BITS-1:0] ent_q [INACTIVE_DEPTH];
  logic [ID_BITS-1:0] ent_d [INACTIVE_DEPTH];
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [ID_BITS-1:0] act_q, act_d;
  logic               act_vld_q, act_vld_d;

  // response register
  logic               out_vld_q, out_vld_d;
  status_e            status_q, status_d;
  logic               ev_flag_q, ev_flag_d;
  logic [ID_BITS-1:0] ev_id_q, ev_id_d;
  logic [CNT_W+3:0]   cnt_ext;

  // FSM controls
  logic accept;
  logic search_en;
  logic last_step;
  logic update_go;

  logic full;
  logic match;
  logic act_match;

  assign last_step = (step_q == IDX_W'(INACTIVE_DEPTH - 1));
  assign full      = (cnt_q == CNT_W'(INACTIVE_DEPTH));
  // shared comparator sits on the ring head
  assign match     = (ent_q[0] == id_q);
  assign act_match = act_vld_q && (act_q == id_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (last_step) state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (!out_vld_q || !out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall_o = 1'b1;
    search_en  = 1'b0;
    update_go  = 1'b0;
    case (state_q)
      S_IDLE:   in_stall_o = 1'b0;
      S_SEARCH: search_en  = 1'b1;
      S_UPDATE: update_go  = !out_vld_q || !out_stall_i;
      default:  in_stall_o = 1'b1;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  // datapath
  always_comb begin
    kind_d    = kind_q;
    id_d      = id_q;
    step_d    = step_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    ent_d     = ent_q;
    cnt_d     = cnt_q;
    act_d     = act_q;
    act_vld_d = act_vld_q;
    status_d  = status_q;
    ev_flag_d = ev_flag_q;
    ev_id_d   = ev_id_q;
    out_vld_d = out_vld_q;

    if (out_vld_q && !out_stall_i) out_vld_d = 1'b0;

    if (accept) begin
      kind_d = kind_e'(kind_i);
      id_d   = session_id_i[ID_BITS-1:0];
      step_d = '0;
      hit_d  = 1'b0;
    end

    if (search_en) begin
      // rotate the ring by one; a full turn restores the order
      for (int i = 0; i < INACTIVE_DEPTH; i++) begin
        ent_d[i] = ent_q[(i + 1) % INACTIVE_DEPTH];
      end
      if (!hit_q && (CNT_W'(step_q) < cnt_q) && match) begin
        hit_d     = 1'b1;
        hit_idx_d = step_q;
      end
      step_d = step_q + IDX_W'(1);
    end

    if (update_go) begin
      out_vld_d = 1'b1;
      ev_flag_d = 1'b0;
      ev_id_d   = '0;
      status_d  = ST_OK;
      if (kind_q == KIND_INSERT) begin
        if (act_match || hit_q) begin
          status_d = ST_COLLIDE;
        end else begin
          if (act_vld_q) begin
            // push old active to head
            ent_d[0] = act_q;
            for (int i = 1; i < INACTIVE_DEPTH; i++) begin
              ent_d[i] = ent_q[i - 1];
            end
            if (full) begin
              ev_flag_d = 1'b1;
              ev_id_d   = ent_q[INACTIVE_DEPTH-1];
            end else begin
              cnt_d = cnt_q + CNT_W'(1);
            end
          end
          act_d     = id_q;
          act_vld_d = 1'b1;
        end
      end else begin
        if (!hit_q) begin
          status_d = ST_NOT_FOUND;
        end else begin
          if (act_vld_q) begin
            // remove hit entry and push old active: count unchanged
            ent_d[0] = act_q;
            for (int i = 1; i < INACTIVE_DEPTH; i++) begin
              if (CNT_W'(i) <= CNT_W'(hit_idx_q)) ent_d[i] = ent_q[i - 1];
            end
          end else begin
            // close the gap, freed slot zeroed
            for (int i = 0; i < INACTIVE_DEPTH; i++) begin
              if (CNT_W'(i) >= CNT_W'(hit_idx_q)) begin
                if (CNT_W'(i) == cnt_q - CNT_W'(1)) ent_d[i] = '0;
                else ent_d[i] = ent_q[(i + 1) % INACTIVE_DEPTH];
              end
            end
            cnt_d = cnt_q - CNT_W'(1);
          end
          act_d     = id_q;
          act_vld_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      kind_q    <= KIND_INSERT;
      id_q      <= '0;
      step_q    <= '0;
      hit_q     <= 1'b0;
      hit_idx_q <= '0;
      for (int i = 0; i < INACTIVE_DEPTH; i++) begin
        ent_q[i] <= '0;
      end
      cnt_q     <= '0;
      act_q     <= '0;
      act_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      status_q  <= ST_OK;
      ev_flag_q <= 1'b0;
      ev_id_q   <= '0;
    end else begin
      state_q   <= state_d;
      kind_q    <= kind_d;
      id_q      <= id_d;
      step_q    <= step_d;
      hit_q     <= hit_d;
      hit_idx_q <= hit_idx_d;
      ent_q     <= ent_d;
      cnt_q     <= cnt_d;
      act_q     <= act_d;
      act_vld_q <= act_vld_d;
      out_vld_q <= out_vld_d;
      status_q  <= status_d;
      ev_flag_q <= ev_flag_d;
      ev_id_q   <= ev_id_d;
    end
  end

  // response ports; active id and count only change as a response is loaded
  assign cnt_ext          = {4'b0000, cnt_q};
  assign out_valid_o      = out_vld_q;
  assign status_o         = status_q;
  assign evicted_flag_o   = ev_flag_q;
  assign evicted_id_o     = FIELD_W'(ev_id_q);
  assign active_valid_o   = act_vld_q;
  assign active_id_o      = FIELD_W'(act_q);
  assign inactive_count_o = cnt_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

// File: verif/session_id_mru_list_checker.sv
// Request/response monitor, MRU list predictor and response scoreboard.
`timescale 1ns / 1ps

module session_id_mru_list_checker #(
  parameter int unsigned ID_BITS        = 64,
  parameter int unsigned INACTIVE_DEPTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic                              kind_i,
  input  logic [smru_pkg::FIELD_W-1:0]      session_id_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [smru_pkg::STATUS_W-1:0]     status_i,
  input  logic                              evicted_flag_i,
  input  logic [smru_pkg::FIELD_W-1:0]      evicted_id_i,
  input  logic                              active_valid_i,
  input  logic [smru_pkg::FIELD_W-1:0]      active_id_i,
  input  logic [smru_pkg::COUNT_W-1:0]      inactive_count_i,
  output int                                fail_count_o,
  output int                                outstanding_o
);
  import smru_pkg::*;

  localparam logic [FIELD_W-1:0] ID_MASK = {FIELD_W{1'b1}} >> (FIELD_W - ID_BITS);

  typedef struct packed {
    status_e              status;
    logic                 evicted;
    logic [FIELD_W-1:0]   evicted_id;
    logic                 active_valid;
    logic [FIELD_W-1:0]   active_id;
    logic [COUNT_W-1:0]   count;
  } mru_result_t;

  // shadow copy of the list state
  logic [FIELD_W-1:0] cur_active;
  logic               active_held;
  logic [FIELD_W-1:0] idle_list [INACTIVE_DEPTH];
  int                 idle_used;

  mru_result_t        expected_q [$];
  int                 mismatches = 0;

  function automatic logic push_front(input logic [FIELD_W-1:0] v,
                                      output logic [FIELD_W-1:0] dropped);
    logic full;
    int   top;
    full    = (idle_used >= INACTIVE_DEPTH);
    top     = full ? INACTIVE_DEPTH - 1 : idle_used;
    dropped = full ? idle_list[INACTIVE_DEPTH-1] : '0;
    for (int i = top; i > 0; i--) idle_list[i] = idle_list[i-1];
    idle_list[0] = v;
    if (!full) idle_used++;
    return full;
  endfunction

  function automatic int find_idle(input logic [FIELD_W-1:0] v);
    for (int i = 0; i < idle_used; i++) begin
      if (idle_list[i] == v) return i;
    end
    return -1;
  endfunction

  function automatic mru_result_t predict_mru(input kind_e kind,
                                              input logic [FIELD_W-1:0] raw_id);
    mru_result_t        r;
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] dropped;
    int                 pos;
    id       = raw_id & ID_MASK;
    r        = '0;
    r.status = ST_OK;
    if (kind == KIND_INSERT) begin
      if ((active_held && cur_active == id) || find_idle(id) >= 0) begin
        r.status = ST_COLLIDE;
      end else begin
        if (active_held) begin
          r.evicted    = push_front(cur_active, dropped);
          r.evicted_id = dropped;
        end
        cur_active  = id;
        active_held = 1'b1;
      end
    end else begin
      pos = find_idle(id);
      if (pos < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        // close the gap, clear the freed tail slot
        for (int i = pos; i + 1 < idle_used; i++) idle_list[i] = idle_list[i+1];
        idle_used--;
        idle_list[idle_used] = '0;
        if (active_held) void'(push_front(cur_active, dropped));
        cur_active  = id;
        active_held = 1'b1;
      end
    end
    r.active_valid = active_held;
    r.active_id    = active_held ? cur_active : '0;
    r.count        = COUNT_W'(idle_used);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [FIELD_W-1:0] exp_v,
                             input logic [FIELD_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    mru_result_t exp_r;
    if (!rst_ni) begin
      cur_active  = '0;
      active_held = 1'b0;
      idle_used   = 0;
      for (int i = 0; i < INACTIVE_DEPTH; i++) idle_list[i] = '0;
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("response with no request outstanding");
          mismatches++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("status", FIELD_W'(exp_r.status), FIELD_W'(status_i));
          check_field("evicted_flag", FIELD_W'(exp_r.evicted), FIELD_W'(evicted_flag_i));
          check_field("evicted_id", exp_r.evicted_id, evicted_id_i);
          check_field("active_valid", FIELD_W'(exp_r.active_valid),
                      FIELD_W'(active_valid_i));
          check_field("active_id", exp_r.active_id, active_id_i);
          check_field("inactive_count", FIELD_W'(exp_r.count), FIELD_W'(inactive_count_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(predict_mru(kind_e'(kind_i), session_id_i));
      end
    end
    outstanding_o <= expected_q.size();
    fail_count_o  <= mismatches;
  end

endmodule

// File: verif/session_id_mru_list_test.sv
// Testbench top: clock, reset, request stimulus, response stalls and verdict.
`timescale 1ns / 1ps

module session_id_mru_list_test;
  import smru_pkg::*;

  localparam int unsigned ID_BITS        = 64;
  localparam int unsigned INACTIVE_DEPTH = 8;
  localparam int          ITEMS_PER_PHASE = 100;
  localparam int          POOL_SIZE       = 12;
  // cycles without any handshake before the run is declared hung; this is far longer than
  // one request's search and update, so it leaves a wide margin for stalls
  localparam int          QUIET_LIMIT     = 2000;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic               req_kind      = KIND_INSERT;
  logic [FIELD_W-1:0] req_id        = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [STATUS_W-1:0] status;
  logic               evicted_flag;
  logic [FIELD_W-1:0] evicted_id;
  logic               active_valid;
  logic [FIELD_W-1:0] active_id;
  logic [COUNT_W-1:0] inactive_count;

  int                 fail_count;
  int                 outstanding;
  int                 send_idle_pct = 0;   // chance per cycle that the sender holds off
  int                 recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  int                 quiet_cycles  = 0;

  // identifiers the random part keeps coming back to, so that inserts collide,
  // activates hit and the list fills up and evicts
  logic [FIELD_W-1:0] id_pool [POOL_SIZE];

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  session_id_mru_list #(
    .ID_BITS        (ID_BITS),
    .INACTIVE_DEPTH (INACTIVE_DEPTH)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .kind_i           (req_kind),
    .session_id_i     (req_id),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .evicted_flag_o   (evicted_flag),
    .evicted_id_o     (evicted_id),
    .active_valid_o   (active_valid),
    .active_id_o      (active_id),
    .inactive_count_o (inactive_count)
  );

  session_id_mru_list_checker #(
    .ID_BITS        (ID_BITS),
    .INACTIVE_DEPTH (INACTIVE_DEPTH)
  ) i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .kind_i           (req_kind),
    .session_id_i     (req_id),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .evicted_flag_i   (evicted_flag),
    .evicted_id_i     (evicted_id),
    .active_valid_i   (active_valid),
    .active_id_i      (active_id),
    .inactive_count_i (inactive_count),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding)
  );

  // Response side: one stall decision per edge, rate set by the current phase.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: any accepted request or response restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // A mix of full-width, small, high-half-only and extreme identifiers.
  function automatic logic [FIELD_W-1:0] pick_id();
    case ($urandom_range(5))
      0:       return FIELD_W'($urandom_range(15));
      1:       return {$urandom, 32'h0};
      2:       return ($urandom_range(1) != 0) ? '1 : '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Drive one request and hold it until the block takes it. The sender may
  // idle first; in_valid gets a single assignment per edge either way.
  task automatic send_request(input kind_e kind, input logic [FIELD_W-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_kind <= kind;
    req_id   <= id;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic send_random_request();
    int pick;
    int slot;
    pick = $urandom_range(99);
    slot = $urandom_range(POOL_SIZE - 1);
    // now and then swap a pool entry so fresh identifiers keep flowing in
    if ($urandom_range(9) == 0) id_pool[slot] = pick_id();
    if (pick < 45)      send_request(KIND_INSERT, id_pool[slot]);
    else if (pick < 85) send_request(KIND_ACTIVATE, id_pool[slot]);
    else if (pick < 93) send_request(KIND_INSERT, pick_id());
    else                send_request(KIND_ACTIVATE, pick_id());
  endtask

  // Walk the list through its corner cases from an empty state.
  task automatic run_directed();
    logic [FIELD_W-1:0] walk [1:9];
    for (int i = 1; i <= 9; i++) walk[i] = FIELD_W'(1) << (7 * i);
    send_request(KIND_ACTIVATE, '0);  // empty list: zeroed slots must not match
    send_request(KIND_INSERT, '0);    // first active id, nothing pushed
    send_request(KIND_INSERT, '0);    // collides with the active id
    send_request(KIND_INSERT, '1);    // pushes 0 to the head
    send_request(KIND_ACTIVATE, '0);  // swap with the active id
    send_request(KIND_ACTIVATE, '1);  // swap back
    send_request(KIND_INSERT, '1);    // collides with the active id
    send_request(KIND_INSERT, '0);    // collides with an inactive id
    // fill the list, then overflow it twice: the two oldest get evicted
    for (int i = 1; i <= 9; i++) send_request(KIND_INSERT, walk[i]);
    send_request(KIND_ACTIVATE, walk[1]);  // tail entry
    send_request(KIND_ACTIVATE, walk[9]);  // now at the head
    send_request(KIND_ACTIVATE, walk[9]);  // the active id is not in the list
    send_request(KIND_ACTIVATE, 64'h5a5a_a5a5_0f0f_f0f0);  // never inserted
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = pick_id();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phases: no idling, sender mostly idle, receiver mostly stalled, both light.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      if (phase == 0) run_directed();
      repeat (ITEMS_PER_PHASE) send_random_request();
    end
    in_valid <= 1'b0;
    @(posedge clk_i);

    // Drain, then give stray responses a chance to show up.
    while (outstanding != 0) @(posedge clk_i);
    repeat (INACTIVE_DEPTH + 4) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/smru_pkg.sv
src/session_id_mru_list.sv
verif/session_id_mru_list_checker.sv
verif/session_id_mru_list_test.sv
